[sv/modbus_meter_frame_parser_unit_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the meter reply parser
// Shorthand for clocked assertions that are disabled while reset is held.
// ---------------------------------------------------------------------------
`ifndef MODBUS_METER_FRAME_PARSER_UNIT_MACROS_SVH
`define MODBUS_METER_FRAME_PARSER_UNIT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define MMFP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define MMFP_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (trig) |=> (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define MMFP_ASSERT_IMPLY(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (trig) |-> (cond)) else $error(msg);

`endif

[sv/mmfp_pkg.sv]
// ---------------------------------------------------------------------------
// Meter reply parser package
// Command and status codes, frame layout and CRC constants.
// ---------------------------------------------------------------------------
package mmfp_pkg;

    // Request command codes.
    typedef enum logic [1:0] {
        CMD_FLUSH   = 2'd0,
        CMD_BYTE    = 2'd1,
        CMD_TIMEOUT = 2'd2
    } cmd_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_CRC_ERR = 2'd1,
        STAT_SHORT   = 2'd2
    } status_t;

    // CRC-16 as used by Modbus RTU (reflected form).
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Frame layout: byte positions within the 25-byte reply.
    localparam logic [4:0] FRAME_LEN     = 5'd25;
    localparam logic [4:0] CRC_END       = 5'd23;
    localparam logic [4:0] POS_VOLT_HI   = 5'd3;
    localparam logic [4:0] POS_VOLT_LO   = 5'd4;
    localparam logic [4:0] POS_CURR_B1   = 5'd5;
    localparam logic [4:0] POS_CURR_B0   = 5'd6;
    localparam logic [4:0] POS_CURR_B3   = 5'd7;
    localparam logic [4:0] POS_CURR_B2   = 5'd8;
    localparam logic [4:0] POS_POWER_B1  = 5'd9;
    localparam logic [4:0] POS_POWER_B0  = 5'd10;
    localparam logic [4:0] POS_POWER_B3  = 5'd11;
    localparam logic [4:0] POS_POWER_B2  = 5'd12;
    localparam logic [4:0] POS_ENERGY_B1 = 5'd13;
    localparam logic [4:0] POS_ENERGY_B0 = 5'd14;
    localparam logic [4:0] POS_ENERGY_B3 = 5'd15;
    localparam logic [4:0] POS_ENERGY_B2 = 5'd16;
    localparam logic [4:0] POS_FREQ_HI   = 5'd17;
    localparam logic [4:0] POS_FREQ_LO   = 5'd18;
    localparam logic [4:0] POS_CRC_LO    = 5'd23;
    localparam logic [4:0] POS_CRC_HI    = 5'd24;

endpackage

[sv/modbus_meter_frame_parser_unit.sv]
// ---------------------------------------------------------------------------
// Modbus RTU meter reply parser
// Checks the CRC of a 25-byte energy-meter reply and extracts raw readings.
// ---------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one request per received event: cmd selects a
//   flush (start of a new frame), a received byte in s_rx_byte, or a
//   receive timeout. The m_ channel returns one result per completed frame:
//   status ok or CRC error on the 25th byte, or a short-frame status when a
//   timeout arrives before the frame is complete. Readings are zero unless
//   the status is ok. Bytes beyond the 25th are dropped.
//   An accepted request sits in the input register and passes the CRC and
//   capture logic into the result register. Throughput is one request per
//   cycle while the result is not stalled, set by the single CRC byte
//   update between the two registers.
//   A stalled result holds in the result register; one further request may
//   wait in the input register, after which s_ready drops until m_ready.
//   Synchronous reset (aresetn low) empties both registers and restarts the
//   frame, as a flush does.
// ---------------------------------------------------------------------------
`include "modbus_meter_frame_parser_unit_macros.svh"

module modbus_meter_frame_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_voltage_raw,
    output logic [31:0] m_current_raw,
    output logic [31:0] m_power_raw,
    output logic [31:0] m_energy_raw,
    output logic [15:0] m_frequency_raw
);

    // Input register.
    logic                in_valid_reg;
    mmfp_pkg::cmd_t      in_cmd_reg;
    logic [7:0]          in_byte_reg;

    // Frame state.
    logic [4:0]          byte_count_reg, byte_count_next;
    logic [15:0]         crc_reg, crc_next;
    logic [7:0]          crc_low_reg, crc_low_next;
    logic [15:0]         voltage_reg, voltage_next;
    logic [31:0]         current_reg, current_next;
    logic [31:0]         power_reg, power_next;
    logic [31:0]         energy_reg, energy_next;
    logic [15:0]         frequency_reg, frequency_next;

    // Result register.
    logic                m_valid_reg;
    mmfp_pkg::status_t   m_status_reg;
    logic [15:0]         m_voltage_reg;
    logic [31:0]         m_current_reg;
    logic [31:0]         m_power_reg;
    logic [31:0]         m_energy_reg;
    logic [15:0]         m_frequency_reg;

    logic                out_free;
    logic                process;
    logic                emit;
    mmfp_pkg::status_t   emit_status;
    logic [15:0]         crc_step;

    // Handshake: the input stage moves on whenever the result slot can load.
    assign out_free = !m_valid_reg || m_ready;
    assign process  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || process;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_cmd_reg  <= mmfp_pkg::cmd_t'(s_cmd);
            in_byte_reg <= s_rx_byte;
        end
    end

    // CRC update for the byte in the input register.
    mmfp_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data_in (in_byte_reg),
        .crc_out (crc_step)
    );

    // Frame state update and result decision.
    always_comb begin
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        crc_low_next    = crc_low_reg;
        voltage_next    = voltage_reg;
        current_next    = current_reg;
        power_next      = power_reg;
        energy_next     = energy_reg;
        frequency_next  = frequency_reg;
        emit            = 1'b0;
        emit_status     = mmfp_pkg::STAT_OK;
        if (process) begin
            unique case (in_cmd_reg)
                mmfp_pkg::CMD_FLUSH: begin
                    byte_count_next = '0;
                    crc_next        = mmfp_pkg::CRC_INIT;
                    crc_low_next    = '0;
                    voltage_next    = '0;
                    current_next    = '0;
                    power_next      = '0;
                    energy_next     = '0;
                    frequency_next  = '0;
                end
                mmfp_pkg::CMD_TIMEOUT: begin
                    if (byte_count_reg < mmfp_pkg::FRAME_LEN) begin
                        byte_count_next = mmfp_pkg::FRAME_LEN;
                        emit            = 1'b1;
                        emit_status     = mmfp_pkg::STAT_SHORT;
                    end
                end
                mmfp_pkg::CMD_BYTE: begin
                    if (byte_count_reg < mmfp_pkg::FRAME_LEN) begin
                        byte_count_next = byte_count_reg + 5'd1;
                        if (byte_count_reg < mmfp_pkg::CRC_END) begin
                            crc_next = crc_step;
                        end
                        // Words are big-endian; 32-bit values send the low word first.
                        unique case (byte_count_reg)
                            mmfp_pkg::POS_VOLT_HI:   voltage_next[15:8]   = in_byte_reg;
                            mmfp_pkg::POS_VOLT_LO:   voltage_next[7:0]    = in_byte_reg;
                            mmfp_pkg::POS_CURR_B1:   current_next[15:8]   = in_byte_reg;
                            mmfp_pkg::POS_CURR_B0:   current_next[7:0]    = in_byte_reg;
                            mmfp_pkg::POS_CURR_B3:   current_next[31:24]  = in_byte_reg;
                            mmfp_pkg::POS_CURR_B2:   current_next[23:16]  = in_byte_reg;
                            mmfp_pkg::POS_POWER_B1:  power_next[15:8]     = in_byte_reg;
                            mmfp_pkg::POS_POWER_B0:  power_next[7:0]      = in_byte_reg;
                            mmfp_pkg::POS_POWER_B3:  power_next[31:24]    = in_byte_reg;
                            mmfp_pkg::POS_POWER_B2:  power_next[23:16]    = in_byte_reg;
                            mmfp_pkg::POS_ENERGY_B1: energy_next[15:8]    = in_byte_reg;
                            mmfp_pkg::POS_ENERGY_B0: energy_next[7:0]     = in_byte_reg;
                            mmfp_pkg::POS_ENERGY_B3: energy_next[31:24]   = in_byte_reg;
                            mmfp_pkg::POS_ENERGY_B2: energy_next[23:16]   = in_byte_reg;
                            mmfp_pkg::POS_FREQ_HI:   frequency_next[15:8] = in_byte_reg;
                            mmfp_pkg::POS_FREQ_LO:   frequency_next[7:0]  = in_byte_reg;
                            mmfp_pkg::POS_CRC_LO:    crc_low_next         = in_byte_reg;
                            mmfp_pkg::POS_CRC_HI: begin
                                emit = 1'b1;
                                if ({in_byte_reg, crc_low_reg} == crc_reg) begin
                                    emit_status = mmfp_pkg::STAT_OK;
                                end else begin
                                    emit_status = mmfp_pkg::STAT_CRC_ERR;
                                end
                            end
                            // Header and power factor bytes are not kept.
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // Frame state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            crc_reg        <= mmfp_pkg::CRC_INIT;
            crc_low_reg    <= '0;
            voltage_reg    <= '0;
            current_reg    <= '0;
            power_reg      <= '0;
            energy_reg     <= '0;
            frequency_reg  <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            crc_low_reg    <= crc_low_next;
            voltage_reg    <= voltage_next;
            current_reg    <= current_next;
            power_reg      <= power_next;
            energy_reg     <= energy_next;
            frequency_reg  <= frequency_next;
        end
    end

    // Result register; readings pass only with an ok status.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= process && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (process && emit) begin
            m_status_reg <= emit_status;
            if (emit_status == mmfp_pkg::STAT_OK) begin
                m_voltage_reg   <= voltage_reg;
                m_current_reg   <= current_reg;
                m_power_reg     <= power_reg;
                m_energy_reg    <= energy_reg;
                m_frequency_reg <= frequency_reg;
            end else begin
                m_voltage_reg   <= '0;
                m_current_reg   <= '0;
                m_power_reg     <= '0;
                m_energy_reg    <= '0;
                m_frequency_reg <= '0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_voltage_raw   = m_voltage_reg;
    assign m_current_raw   = m_current_reg;
    assign m_power_raw     = m_power_reg;
    assign m_energy_raw    = m_energy_reg;
    assign m_frequency_raw = m_frequency_reg;

    // The byte counter never runs past the end of the frame.
    `MMFP_ASSERT_ALWAYS(a_count_range, byte_count_reg <= mmfp_pkg::FRAME_LEN,
        "byte counter beyond frame length")

    // Every result closes the frame.
    `MMFP_ASSERT_NEXT(a_emit_closes, process && emit,
        byte_count_reg == mmfp_pkg::FRAME_LEN, "frame still open after a result")

    // A failed frame carries no readings.
    `MMFP_ASSERT_IMPLY(a_fail_zero, m_valid_reg && m_status_reg != mmfp_pkg::STAT_OK,
        m_voltage_reg == '0 && m_current_reg == '0 && m_power_reg == '0
            && m_energy_reg == '0 && m_frequency_reg == '0,
        "readings present on a failed frame")

endmodule

[sv/mmfp_crc_byte.sv]
// ---------------------------------------------------------------------------
// CRC-16 byte update
// Folds one byte into the running reflected CRC-16, eight bit steps unrolled.
// ---------------------------------------------------------------------------
module mmfp_crc_byte (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    // Shift out eight bits, applying the polynomial when the low bit is set.
    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = {1'b0, c[15:1]} ^ mmfp_pkg::CRC_POLY;
            end else begin
                c = {1'b0, c[15:1]};
            end
        end
        crc_out = c;
    end

endmodule
